// ===== rtl/dvp_pkg.sv =====
// ----------------------------------------------------------------------------
// dvp_pkg
// Shared constants, types and register indexes of the dipole potential block.
// ----------------------------------------------------------------------------
package dvp_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = DATA_W + DIFF_W;
  localparam int SQ_W      = 2 * DIFF_W - 1 - FRAC_BITS;
  localparam int R2_W      = SQ_W + 2;
  localparam int RAD_W     = ((R2_W + FRAC_BITS + 1) / 2) * 2;
  localparam int ROOT_W    = RAD_W / 2;
  localparam int LO_W      = (R2_W + 1) / 2;
  localparam int HI_W      = R2_W - LO_W;
  localparam int DEN_W     = R2_W + ROOT_W;
  localparam int NUM_W     = PROD_W + FRAC_BITS;
  localparam int QUOT_W    = DATA_W;
  localparam int CMP_W     = DEN_W + QUOT_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [R2_W-1:0] R2_MIN = R2_W'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MOMENT_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MIRROR_X = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_R2 = 3'd7;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic zero;
    logic neg;
  } flags_t;

  typedef struct packed {
    flags_t              flags;
    logic [PROD_W-1:0]   mag;
    logic [R2_W-1:0]     r2;
  } side_t;

endpackage

// ===== rtl/dvp_if.sv =====
// ----------------------------------------------------------------------------
// dvp_if
// Word channels of the dipole potential block: positions in, potentials out.
// ----------------------------------------------------------------------------
interface dvp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic [1:0]         component;

  modport source(output valid, pos_x, pos_y, pos_z, component, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, component, output ready);
endinterface

interface dvp_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] potential;
  logic               saturated;

  modport source(output valid, potential, saturated, input ready);
  modport sink(input valid, potential, saturated, output ready);
endinterface

// ===== rtl/dipole_vector_potential.sv =====
// ----------------------------------------------------------------------------
// dipole_vector_potential
// One component of a magnetic dipole vector potential per position word.
// ----------------------------------------------------------------------------
// Takes one position word per clock when not stalled and returns one potential
// word per position, in order, through three front stages (offset, squares and
// cross products, radius and sign), a 34-stage square root, two stages for the
// r2 * r product, a 33-stage divider and the output register. A stall on the
// result side holds the whole pipeline, so ready follows the output register.
// The user must write configuration via cfg_wen / cfg_index / cfg_data only while idle; it is not enforced.
module dipole_vector_potential (
  input  logic                           clk,
  input  logic                           rst,
  dvp_in_if.sink                         sample,
  dvp_out_if.source                      result,
  input  logic                           cfg_wen,
  input  logic [dvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int F = dvp_pkg::FRAC_BITS;

  logic signed [31:0] center_x, center_y, center_z;
  logic signed [31:0] moment_x, moment_y, moment_z;
  logic signed [31:0] mirror_x;
  logic [31:0]        inner_radius_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x        <= '0;
      center_y        <= '0;
      center_z        <= '0;
      moment_x        <= '0;
      moment_y        <= '0;
      moment_z        <= '0;
      mirror_x        <= '0;
      inner_radius_sq <= '0;
    end else if (cfg_wen) begin
      case (cfg_index)
        dvp_pkg::CFG_CENTER_X: center_x        <= cfg_data;
        dvp_pkg::CFG_CENTER_Y: center_y        <= cfg_data;
        dvp_pkg::CFG_CENTER_Z: center_z        <= cfg_data;
        dvp_pkg::CFG_MOMENT_X: moment_x        <= cfg_data;
        dvp_pkg::CFG_MOMENT_Y: moment_y        <= cfg_data;
        dvp_pkg::CFG_MOMENT_Z: moment_z        <= cfg_data;
        dvp_pkg::CFG_MIRROR_X: mirror_x        <= cfg_data;
        dvp_pkg::CFG_INNER_R2: inner_radius_sq <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !result.valid || result.ready;
  assign sample.ready = en;

  // stage 1: offsets
  logic                              v1;
  logic signed [dvp_pkg::DIFF_W-1:0] dx1, dy1, dz1;
  logic                              mir1;
  logic [1:0]                        comp1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= sample.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx1   <= $signed({sample.pos_x[31], sample.pos_x}) - $signed({center_x[31], center_x});
      dy1   <= $signed({sample.pos_y[31], sample.pos_y}) - $signed({center_y[31], center_y});
      dz1   <= $signed({sample.pos_z[31], sample.pos_z}) - $signed({center_z[31], center_z});
      mir1  <= (mirror_x != '0) && (sample.pos_x < mirror_x);
      comp1 <= sample.component;
    end
  end

  // stage 2: squares and cross products
  logic [dvp_pkg::DIFF_W-1:0]         adx, ady, adz;
  logic [2*dvp_pkg::DIFF_W-1:0]       sqx, sqy, sqz;
  logic signed [31:0]                 ma, mb;
  logic signed [dvp_pkg::DIFF_W-1:0]  da, db;
  logic                               bad_comp;
  logic signed [dvp_pkg::PROD_W-1:0]  prod1, prod2;

  always_comb begin
    adx = dx1[dvp_pkg::DIFF_W-1] ? -dx1 : dx1;
    ady = dy1[dvp_pkg::DIFF_W-1] ? -dy1 : dy1;
    adz = dz1[dvp_pkg::DIFF_W-1] ? -dz1 : dz1;
    sqx = adx * adx;
    sqy = ady * ady;
    sqz = adz * adz;
    bad_comp = 1'b0;
    case (comp1)
      dvp_pkg::COMP_X: begin ma = moment_y; da = dz1; mb = moment_z; db = dy1; end
      dvp_pkg::COMP_Y: begin ma = moment_z; da = dx1; mb = moment_x; db = dz1; end
      dvp_pkg::COMP_Z: begin ma = moment_x; da = dy1; mb = moment_y; db = dx1; end
      default: begin
        ma = '0; da = '0; mb = '0; db = '0;
        bad_comp = 1'b1;
      end
    endcase
    prod1 = ma * da;
    prod2 = mb * db;
  end

  logic                              v2;
  logic [dvp_pkg::SQ_W-1:0]          sqx2, sqy2, sqz2;
  logic signed [dvp_pkg::PROD_W-1:0] p1_2, p2_2;
  logic                              kill2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2  <= sqx[dvp_pkg::SQ_W+F-1:F];
      sqy2  <= sqy[dvp_pkg::SQ_W+F-1:F];
      sqz2  <= sqz[dvp_pkg::SQ_W+F-1:F];
      p1_2  <= prod1;
      p2_2  <= prod2;
      kill2 <= mir1 || bad_comp;
    end
  end

  // stage 3: radius squared, sign and magnitude
  logic [dvp_pkg::R2_W-1:0]          r2_sum, r2_fl;
  logic signed [dvp_pkg::PROD_W:0]   diff;
  logic                              neg3;
  dvp_pkg::side_t                    side3_next;

  always_comb begin
    r2_sum = dvp_pkg::R2_W'(sqx2) + dvp_pkg::R2_W'(sqy2) + dvp_pkg::R2_W'(sqz2);
    r2_fl  = (r2_sum < dvp_pkg::R2_MIN) ? dvp_pkg::R2_MIN : r2_sum;
    neg3   = p1_2 < p2_2;
    diff   = $signed({p1_2[dvp_pkg::PROD_W-1], p1_2}) - $signed({p2_2[dvp_pkg::PROD_W-1], p2_2});
    side3_next.r2         = r2_fl;
    side3_next.flags.neg  = neg3;
    side3_next.flags.zero = kill2 || (r2_fl <= dvp_pkg::R2_W'(inner_radius_sq));
    side3_next.mag        = neg3 ? dvp_pkg::PROD_W'(-diff) : dvp_pkg::PROD_W'(diff);
  end

  logic           v3;
  dvp_pkg::side_t side3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3 <= side3_next;
    end
  end

  logic                        v4;
  logic [dvp_pkg::ROOT_W-1:0]  root4;
  dvp_pkg::side_t              side4;

  dvp_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .in_side  (side3),
    .out_valid(v4),
    .root     (root4),
    .out_side (side4)
  );

  // denominator r2 * r in two partial products
  logic                                     v5;
  logic [dvp_pkg::LO_W+dvp_pkg::ROOT_W-1:0] pp_lo;
  logic [dvp_pkg::HI_W+dvp_pkg::ROOT_W-1:0] pp_hi;
  logic [dvp_pkg::NUM_W-1:0]                num5;
  dvp_pkg::flags_t                          fl5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_lo <= side4.r2[dvp_pkg::LO_W-1:0] * root4;
      pp_hi <= side4.r2[dvp_pkg::R2_W-1:dvp_pkg::LO_W] * root4;
      num5  <= {side4.mag, {F{1'b0}}};
      fl5   <= side4.flags;
    end
  end

  logic                       v6;
  logic [dvp_pkg::DEN_W-1:0]  den6;
  logic [dvp_pkg::NUM_W-1:0]  num6;
  dvp_pkg::flags_t            fl6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den6 <= dvp_pkg::DEN_W'(pp_lo) + (dvp_pkg::DEN_W'(pp_hi) << dvp_pkg::LO_W);
      num6 <= num5;
      fl6  <= fl5;
    end
  end

  logic                        v7;
  logic [dvp_pkg::QUOT_W-1:0]  quot7;
  logic                        ovf7;
  dvp_pkg::flags_t             fl7;

  dvp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v6),
    .num      (num6),
    .den      (den6),
    .in_flags (fl6),
    .out_valid(v7),
    .quot     (quot7),
    .ovf      (ovf7),
    .out_flags(fl7)
  );

  // clip and sign
  logic [31:0] limit;
  logic        sat;
  logic [31:0] mag_out;
  logic [31:0] pot_next;
  logic        sat_next;

  always_comb begin
    limit   = fl7.neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    sat     = ovf7 || (quot7 > limit);
    mag_out = sat ? limit : quot7;
    if (fl7.zero) begin
      pot_next = '0;
      sat_next = 1'b0;
    end else begin
      pot_next = fl7.neg ? -mag_out : mag_out;
      sat_next = sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (en) begin
      result.valid <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.potential <= pot_next;
      result.saturated <= sat_next;
    end
  end

`ifndef SYNTH
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.saturated |->
      (result.potential == 32'h7FFF_FFFF || result.potential == 32'h8000_0000))
    else $error("saturated word not at a clip value");

  a_zero_path: assert property (@(posedge clk) disable iff (rst)
    v7 && en && fl7.zero |=> (result.potential == '0 && !result.saturated))
    else $error("masked position gave nonzero potential");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result.valid)
    else $error("result valid right after reset");
`endif

endmodule

// ===== rtl/dvp_sqrt.sv =====
// ----------------------------------------------------------------------------
// dvp_sqrt
// Pipelined integer square root of r2 * 2^F, one root bit per stage.
// ----------------------------------------------------------------------------
module dvp_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  dvp_pkg::side_t              in_side,
  output logic                        out_valid,
  output logic [dvp_pkg::ROOT_W-1:0]  root,
  output dvp_pkg::side_t              out_side
);

  localparam int RW = dvp_pkg::ROOT_W;

  logic                       vld  [0:RW];
  logic [RW+1:0]              rem  [0:RW];
  logic [RW-1:0]              rt   [0:RW];
  logic [dvp_pkg::RAD_W-1:0]  rad  [0:RW];
  dvp_pkg::side_t             sd   [0:RW];

  assign vld[0] = in_valid;
  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign rad[0] = (dvp_pkg::RAD_W)'({in_side.r2, {dvp_pkg::FRAC_BITS{1'b0}}});
  assign sd[0]  = in_side;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    logic [RW+1:0]             rem_t;
    logic [RW+1:0]             trial;
    logic                      ge;
    logic                      vld_q;
    logic [RW+1:0]             rem_q;
    logic [RW-1:0]             rt_q;
    logic [dvp_pkg::RAD_W-1:0] rad_q;
    dvp_pkg::side_t            sd_q;

    always_comb begin
      rem_t = {rem[j][RW-1:0], rad[j][dvp_pkg::RAD_W-1 -: 2]};
      trial = {rt[j], 2'b01};
      ge    = rem_t >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= ge ? rem_t - trial : rem_t;
        rt_q  <= {rt[j][RW-2:0], ge};
        rad_q <= rad[j] << 2;
        sd_q  <= sd[j];
      end
    end

    assign vld[j+1] = vld_q;
    assign rem[j+1] = rem_q;
    assign rt[j+1]  = rt_q;
    assign rad[j+1] = rad_q;
    assign sd[j+1]  = sd_q;
  end

  assign out_valid = vld[RW];
  assign root      = rt[RW];
  assign out_side  = sd[RW];

endmodule

// ===== rtl/dvp_div.sv =====
// ----------------------------------------------------------------------------
// dvp_div
// Pipelined restoring divider: overflow check, then one quotient bit a stage.
// ----------------------------------------------------------------------------
module dvp_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [dvp_pkg::NUM_W-1:0]   num,
  input  logic [dvp_pkg::DEN_W-1:0]   den,
  input  dvp_pkg::flags_t             in_flags,
  output logic                        out_valid,
  output logic [dvp_pkg::QUOT_W-1:0]  quot,
  output logic                        ovf,
  output dvp_pkg::flags_t             out_flags
);

  localparam int QW = dvp_pkg::QUOT_W;
  localparam int CW = dvp_pkg::CMP_W;

  logic                       vld [0:QW];
  logic [dvp_pkg::NUM_W-1:0]  rem [0:QW];
  logic [dvp_pkg::DEN_W-1:0]  dv  [0:QW];
  logic [QW-1:0]              q   [0:QW];
  logic                       ov  [0:QW];
  dvp_pkg::flags_t            fl  [0:QW];

  logic                       vld0;
  logic [dvp_pkg::NUM_W-1:0]  rem0;
  logic [dvp_pkg::DEN_W-1:0]  dv0;
  logic                       ov0;
  dvp_pkg::flags_t            fl0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld0 <= 1'b0;
    end else if (en) begin
      vld0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem0 <= num;
      dv0  <= den;
      ov0  <= CW'(num) >= (CW'(den) << QW);
      fl0  <= in_flags;
    end
  end

  assign vld[0] = vld0;
  assign rem[0] = rem0;
  assign dv[0]  = dv0;
  assign q[0]   = '0;
  assign ov[0]  = ov0;
  assign fl[0]  = fl0;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [CW-1:0]              shifted;
    logic                       ge;
    logic [QW-1:0]              q_next;
    logic                       vld_q;
    logic [dvp_pkg::NUM_W-1:0]  rem_q;
    logic [dvp_pkg::DEN_W-1:0]  dv_q;
    logic [QW-1:0]              q_q;
    logic                       ov_q;
    dvp_pkg::flags_t            fl_q;

    always_comb begin
      shifted   = CW'(dv[k]) << B;
      ge        = CW'(rem[k]) >= shifted;
      q_next    = q[k];
      q_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q <= 1'b0;
      end else if (en) begin
        vld_q <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q <= ge ? dvp_pkg::NUM_W'(CW'(rem[k]) - shifted) : rem[k];
        dv_q  <= dv[k];
        q_q   <= q_next;
        ov_q  <= ov[k];
        fl_q  <= fl[k];
      end
    end

    assign vld[k+1] = vld_q;
    assign rem[k+1] = rem_q;
    assign dv[k+1]  = dv_q;
    assign q[k+1]   = q_q;
    assign ov[k+1]  = ov_q;
    assign fl[k+1]  = fl_q;
  end

  assign out_valid = vld[QW];
  assign quot      = q[QW];
  assign ovf       = ov[QW];
  assign out_flags = fl[QW];

endmodule

// ===== dv/dvp_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dvp_tb_if
// Word channels of the dipole potential block, as used by its testbench.
// ----------------------------------------------------------------------------
// The block's own channel interfaces (dvp_in_if, dvp_out_if) are part of the
// RTL and are connected directly; this file only carries the word types the
// bench uses to keep its stimulus and expected results.
package dvp_tb_types;
  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic [1:0]         comp;
  } position_t;

  typedef struct {
    logic signed [31:0] potential;
    logic               saturated;
  } potential_t;
endpackage

// ===== dv/dipole_vector_potential_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dipole_vector_potential_tb
// Self-checking bench for the dipole vector potential pipeline.
// ----------------------------------------------------------------------------
// Streams position words through the block under several register settings,
// predicts each potential word in wide integer arithmetic and compares every
// result in order. Both channels idle at random; one long output stall fills
// the pipeline so that it backs up onto its input.
module dipole_vector_potential_tb;

  localparam int F = dvp_pkg::FRAC_BITS;
  localparam int LATENCY = 80;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [dvp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [31:0] cfg_data;

  dvp_in_if sample ();
  dvp_out_if result ();

  dipole_vector_potential uut (
    .clk(clk), .rst(rst), .sample(sample), .result(result),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  logic signed [31:0] ctr_x, ctr_y, ctr_z, mom_x, mom_y, mom_z, mirror;
  logic [31:0] inner_r2;

  dvp_tb_types::potential_t expected_q[$];
  int errors = 0;
  int sent = 0;
  int received = 0;
  int saturations = 0;
  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  bit hold_off = 0;
  bit stalled_input = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("Test completed with failures");
    $finish;
  end

  function automatic logic [255:0] isqrt(logic [255:0] rad);
    logic [255:0] res;
    logic [255:0] cand;
    res = 0;
    for (int b = 40; b >= 0; b--) begin
      cand = res | (256'd1 << b);
      if (cand * cand <= rad) res = cand;
    end
    return res;
  endfunction

  function automatic dvp_tb_types::potential_t predict_potential(dvp_tb_types::position_t p);
    dvp_tb_types::potential_t r;
    logic signed [63:0] dx, dy, dz, p1, p2;
    logic [63:0] ax, ay, az;
    logic [63:0] dmag;
    logic [255:0] r2, s, mag, q, limit;
    logic neg;
    r.potential = 0;
    r.saturated = 0;
    dx = 64'(p.px) - 64'(ctr_x);
    dy = 64'(p.py) - 64'(ctr_y);
    dz = 64'(p.pz) - 64'(ctr_z);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    az = dz < 0 ? -dz : dz;
    r2 = ((256'(ax) * ax) >> F) + ((256'(ay) * ay) >> F) + ((256'(az) * az) >> F);
    if (r2 < 256'(dvp_pkg::R2_MIN)) r2 = 256'(dvp_pkg::R2_MIN);
    if (r2 <= 256'(inner_r2)) return r;
    if (mirror != 0 && p.px < mirror) return r;
    case (p.comp)
      dvp_pkg::COMP_X: begin p1 = 64'(mom_y) * dz; p2 = 64'(mom_z) * dy; end
      dvp_pkg::COMP_Y: begin p1 = 64'(mom_z) * dx; p2 = 64'(mom_x) * dz; end
      dvp_pkg::COMP_Z: begin p1 = 64'(mom_x) * dy; p2 = 64'(mom_y) * dx; end
      default: return r;
    endcase
    neg = p1 < p2;
    // difference taken modulo 2^64: the magnitude can reach 64 bits
    dmag = neg ? p2 - p1 : p1 - p2;
    mag = 256'(dmag);
    s = isqrt(r2 << F);
    q = (mag << F) / (r2 * s);
    limit = neg ? 256'h8000_0000 : 256'h7FFF_FFFF;
    if (q > limit) begin
      q = limit;
      r.saturated = 1;
    end
    r.potential = neg ? -q[31:0] : q[31:0];
    return r;
  endfunction

  task automatic write_reg(logic [dvp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 0;
    case (idx)
      dvp_pkg::CFG_CENTER_X: ctr_x = val;
      dvp_pkg::CFG_CENTER_Y: ctr_y = val;
      dvp_pkg::CFG_CENTER_Z: ctr_z = val;
      dvp_pkg::CFG_MOMENT_X: mom_x = val;
      dvp_pkg::CFG_MOMENT_Y: mom_y = val;
      dvp_pkg::CFG_MOMENT_Z: mom_z = val;
      dvp_pkg::CFG_MIRROR_X: mirror = val;
      default: inner_r2 = val;
    endcase
    @(posedge clk);
  endtask

  task automatic send_position(dvp_tb_types::position_t p, bit check_typed,
                               dvp_tb_types::potential_t typed);
    dvp_tb_types::potential_t e;
    while (src_idle_pct > 0 && $urandom_range(99, 0) < src_idle_pct) begin
      sample.valid <= 0;
      @(posedge clk);
    end
    sample.valid <= 1;
    sample.pos_x <= p.px;
    sample.pos_y <= p.py;
    sample.pos_z <= p.pz;
    sample.component <= p.comp;
    @(posedge clk);
    while (!sample.ready) begin
      if (hold_off) stalled_input = 1;
      @(posedge clk);
    end
    e = predict_potential(p);
    if (check_typed && (e.potential !== typed.potential || e.saturated !== typed.saturated)) begin
      $error("directed row: expected %0d/%0b, predicted %0d/%0b",
             typed.potential, typed.saturated, e.potential, e.saturated);
      errors++;
    end
    expected_q.push_back(check_typed ? typed : e);
    sent++;
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    sample.valid <= 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY) @(posedge clk);
  endtask

  // result sink
  always @(posedge clk) begin
    dvp_tb_types::potential_t e;
    if (!rst && result.valid && result.ready) begin
      received++;
      if (expected_q.size() == 0) begin
        $error("potential word with nothing expected: %0d", result.potential);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (result.potential !== e.potential) begin
          $error("potential: expected %0d actual %0d", e.potential, result.potential);
          errors++;
        end
        if (result.saturated !== e.saturated) begin
          $error("saturated: expected %0b actual %0b", e.saturated, result.saturated);
          errors++;
        end
        if (result.saturated) saturations++;
      end
    end
    if (rst) result.ready <= 0;
    else if (hold_off) result.ready <= 0;
    else result.ready <= !(snk_idle_pct > 0 && $urandom_range(99, 0) < snk_idle_pct);
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(5, 0))
      0: return $urandom();
      1: return 32'(int'($urandom_range(20, 0)) - 10) <<< F;
      2: return $urandom_range(2000, 0) - 1000;
      default: return 32'(int'($urandom_range(400, 0)) - 200) <<< (F - 2);
    endcase
  endfunction

  function automatic dvp_tb_types::position_t rand_position();
    dvp_tb_types::position_t p;
    p.px = rand_coord();
    p.py = rand_coord();
    p.pz = rand_coord();
    p.comp = ($urandom_range(15, 0) == 0) ? 2'd3 : 2'($urandom_range(2, 0));
    return p;
  endfunction

  dvp_tb_types::position_t dir_pos[$];
  bit dir_typed[$];
  dvp_tb_types::potential_t dir_res[$];

  task automatic add_row(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [1:0] c,
                         bit typed = 0, logic [31:0] pot = 0, logic sat = 0);
    dvp_tb_types::position_t p;
    dvp_tb_types::potential_t r;
    p.px = x; p.py = y; p.pz = z; p.comp = c;
    r.potential = pot; r.saturated = sat;
    dir_pos.push_back(p);
    dir_typed.push_back(typed);
    dir_res.push_back(r);
  endtask

  initial begin
    dvp_tb_types::position_t p;
    int n;
    rst = 1;
    cfg_wen = 0;
    cfg_index = 0;
    cfg_data = 0;
    sample.valid = 0;
    sample.pos_x = 0;
    sample.pos_y = 0;
    sample.pos_z = 0;
    sample.component = 0;
    {ctr_x, ctr_y, ctr_z, mom_x, mom_y, mom_z, mirror, inner_r2} = '0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // after reset the moment is zero: every component is zero
    add_row(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, dvp_pkg::COMP_X, 1, 0, 0);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, dvp_pkg::COMP_Z, 1, 0, 0);
    add_row(0, 0, 0, 2'd3, 1, 0, 0);
    foreach (dir_pos[i]) send_position(dir_pos[i], dir_typed[i], dir_res[i]);
    drain();

    write_reg(dvp_pkg::CFG_MOMENT_X, 32'h0001_0000);
    write_reg(dvp_pkg::CFG_MOMENT_Y, 32'hFFFE_0000);
    write_reg(dvp_pkg::CFG_MOMENT_Z, 32'h0000_8000);
    dir_pos.delete(); dir_typed.delete(); dir_res.delete();
    // centre point: radius floored, big cross product at extremes
    add_row(0, 0, 0, dvp_pkg::COMP_X);
    add_row(0, 0, 0, 2'd3, 1, 0, 0);
    add_row(32'h0000_0100, 32'h0000_0100, 0, dvp_pkg::COMP_Z);
    add_row(32'h0001_0000, 0, 0, dvp_pkg::COMP_Y);
    add_row(0, 32'h0001_0000, 0, dvp_pkg::COMP_X);
    add_row(0, 0, 32'h0001_0000, dvp_pkg::COMP_X);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, dvp_pkg::COMP_X);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, dvp_pkg::COMP_Y);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 0, dvp_pkg::COMP_Z);
    add_row(32'h0000_0010, 32'h0000_0020, 32'h0000_0008, dvp_pkg::COMP_Y);
    add_row(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, dvp_pkg::COMP_Z);
    foreach (dir_pos[i]) send_position(dir_pos[i], dir_typed[i], dir_res[i]);
    drain();

    // extreme moments and centre offsets, inner radius and mirror
    write_reg(dvp_pkg::CFG_MOMENT_X, 32'h7FFF_FFFF);
    write_reg(dvp_pkg::CFG_MOMENT_Y, 32'h8000_0000);
    write_reg(dvp_pkg::CFG_MOMENT_Z, 32'h7FFF_FFFF);
    write_reg(dvp_pkg::CFG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(dvp_pkg::CFG_CENTER_Y, 32'h8000_0000);
    write_reg(dvp_pkg::CFG_CENTER_Z, 32'h0001_0000);
    dir_pos.delete(); dir_typed.delete(); dir_res.delete();
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, dvp_pkg::COMP_X);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, dvp_pkg::COMP_Y);
    add_row(32'h7FFF_0000, 32'h8001_0000, 0, dvp_pkg::COMP_Z);
    foreach (dir_pos[i]) send_position(dir_pos[i], dir_typed[i], dir_res[i]);
    drain();
    write_reg(dvp_pkg::CFG_CENTER_X, 0);
    write_reg(dvp_pkg::CFG_CENTER_Y, 0);
    write_reg(dvp_pkg::CFG_CENTER_Z, 0);
    write_reg(dvp_pkg::CFG_INNER_R2, 32'h0004_0000);
    write_reg(dvp_pkg::CFG_MIRROR_X, 32'hFFFE_0000);
    dir_pos.delete(); dir_typed.delete(); dir_res.delete();
    // inside inner radius, on its edge, outside it, sunward of mirror, on the mirror
    add_row(32'h0001_0000, 0, 0, dvp_pkg::COMP_Y, 1, 0, 0);
    add_row(32'h0002_0000, 0, 0, dvp_pkg::COMP_Y, 1, 0, 0);
    add_row(32'h0003_0000, 0, 0, dvp_pkg::COMP_Y);
    add_row(32'hFFFD_0000, 32'h0005_0000, 0, dvp_pkg::COMP_Z, 1, 0, 0);
    add_row(32'hFFFE_0000, 32'h0005_0000, 0, dvp_pkg::COMP_Z);
    foreach (dir_pos[i]) send_position(dir_pos[i], dir_typed[i], dir_res[i]);
    drain();
    write_reg(dvp_pkg::CFG_INNER_R2, 32'hFFFF_FFFF);
    send_position('{32'h00FF_0000, 0, 0, dvp_pkg::COMP_Y}, 1, '{0, 0});
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      write_reg(dvp_pkg::CFG_CENTER_X, rand_coord());
      write_reg(dvp_pkg::CFG_CENTER_Y, rand_coord());
      write_reg(dvp_pkg::CFG_CENTER_Z, rand_coord());
      write_reg(dvp_pkg::CFG_MOMENT_X, phase == 2 ? $urandom() : rand_coord());
      write_reg(dvp_pkg::CFG_MOMENT_Y, rand_coord());
      write_reg(dvp_pkg::CFG_MOMENT_Z, rand_coord());
      write_reg(dvp_pkg::CFG_MIRROR_X, phase == 1 ? 32'hFFF8_0000 : 0);
      write_reg(dvp_pkg::CFG_INNER_R2, phase == 0 ? 0 : $urandom_range(32'h0002_0000, 0));
      src_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 59 : 0;
      snk_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 11 : 0;
      n = 0;
      fork
        begin
          if (phase == 2) begin
            repeat (30) @(posedge clk);
            hold_off = 1;
            repeat (300) @(posedge clk);
            hold_off = 0;
          end
        end
        begin
          while (n < 300) begin
            p = rand_position();
            send_position(p, 0, '{0, 0});
            n++;
          end
        end
      join
      drain();
    end

    $display("Sent %0d position words, %0d potential words checked, %0d saturated.",
             sent, received, saturations);
    $display("Input stalled under output hold-off: %0d", stalled_input);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
